@@ rtl/core/pooled_linked_fifo_queue_macros.svh @@
// assertion macros for the pooled linked fifo queue
`ifndef POOLED_LINKED_FIFO_QUEUE_MACROS_SVH
`define POOLED_LINKED_FIFO_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define PLFQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("plfq assertion failed");
`define PLFQ_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("plfq assertion failed");
`else
`define PLFQ_ASSERT(lbl, clk, rstn, prop)
`define PLFQ_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ rtl/core/plfq_pkg.sv @@
// shared types and constants of the pooled linked fifo queue
`default_nettype none
package plfq_pkg;

  localparam int POOL_ENTRIES_DEF = 16;
  localparam int DATA_BITS_DEF    = 32;
  localparam int WORD_W           = 32;
  localparam int FUNC_W           = 2;
  localparam int STATUS_W         = 2;
  localparam int COUNT_OUT_W      = 5;
  localparam int SCAN_GROUP       = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] data_value;
  } plfq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [WORD_W-1:0]      popped_value;
    logic [WORD_W-1:0]      head_value;
    logic [COUNT_OUT_W-1:0] entry_count;
  } plfq_out_t;

  // controller to datapath
  typedef struct packed {
    logic    latch_in;
    logic    decode;
    logic    status_we;
    status_e status_code;
    logic    scan;
    logic    push_commit;
    logic    pop_commit;
    logic    walk_step;
    logic    rm_commit;
    logic    head_load;
    logic    resp_load;
  } plfq_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_e func;
    logic  is_full;
    logic  is_empty;
    logic  scan_hit;
    logic  walk_match;
    logic  walk_last;
    logic  count_one;
    logic  e_is_head;
    logic  out_free;
  } plfq_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/plfq_ram.sv @@
// generic single write, single read ram with registered read data
`default_nettype none
module plfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/plfq_ctrl.sv @@
// control state machine of the pooled linked fifo queue
`default_nettype none
module plfq_ctrl
  import plfq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire plfq_stat_t stat_i,
  output plfq_cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_DECODE     = 11'b000_0000_0010,
    S_SCAN       = 11'b000_0000_0100,
    S_PUSH_WR    = 11'b000_0000_1000,
    S_POP_RD     = 11'b000_0001_0000,
    S_POP_NX     = 11'b000_0010_0000,
    S_WALK_RD    = 11'b000_0100_0000,
    S_WALK       = 11'b000_1000_0000,
    S_HEAD_FETCH = 11'b001_0000_0000,
    S_HEAD_LOAD  = 11'b010_0000_0000,
    S_DONE       = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.status_code = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode    = 1'b1;
        cmd_o.status_we = 1'b1;
        case (stat_i.func)
          FN_PUSH: begin
            if (stat_i.is_full) begin
              cmd_o.status_code = ST_FULL;
              state_d           = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
          FN_POP: begin
            if (stat_i.is_empty) begin
              cmd_o.status_code = ST_EMPTY;
              state_d           = S_DONE;
            end else begin
              state_d = S_POP_RD;
            end
          end
          FN_REMOVE: begin
            if (stat_i.is_empty) begin
              cmd_o.status_code = ST_EMPTY;
              state_d           = S_DONE;
            end else begin
              state_d = S_WALK_RD;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_hit) begin
          state_d = S_PUSH_WR;
        end
      end
      S_PUSH_WR: begin
        cmd_o.push_commit = 1'b1;
        state_d           = S_DONE;
      end
      S_POP_RD: begin
        state_d = S_POP_NX;
      end
      S_POP_NX: begin
        cmd_o.pop_commit = 1'b1;
        state_d          = stat_i.count_one ? S_DONE : S_HEAD_FETCH;
      end
      S_WALK_RD: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (stat_i.walk_match) begin
          cmd_o.rm_commit = 1'b1;
          if (!stat_i.count_one && stat_i.e_is_head) begin
            state_d = S_HEAD_FETCH;
          end else begin
            state_d = S_DONE;
          end
        end else if (stat_i.walk_last) begin
          cmd_o.status_we   = 1'b1;
          cmd_o.status_code = ST_NOT_FOUND;
          state_d           = S_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_HEAD_FETCH: begin
        state_d = S_HEAD_LOAD;
      end
      S_HEAD_LOAD: begin
        cmd_o.head_load = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/plfq_dp.sv @@
// datapath of the pooled linked fifo queue: pool rams, list pointers, result register
`default_nettype none
`include "pooled_linked_fifo_queue_macros.svh"
module plfq_dp
  import plfq_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int DATA_BITS    = DATA_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire plfq_in_t  in_word_i,
  input  wire plfq_cmd_t cmd_i,
  output plfq_stat_t     stat_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output plfq_out_t      out_word_o
);

  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int NG    = (POOL_ENTRIES + SCAN_GROUP - 1) / SCAN_GROUP;
  localparam int CHK_W = (NG > 1) ? $clog2(NG) : 1;
  localparam int GRP_W = $clog2(SCAN_GROUP);
  localparam int PAD_W = NG * SCAN_GROUP;

  logic [FUNC_W-1:0]       func_q;
  logic [DATA_BITS-1:0]    val_q;
  logic [IDX_W-1:0]        head_q, tail_q;
  logic [CNT_W-1:0]        count_q;
  logic [POOL_ENTRIES-1:0] used_q;
  logic [DATA_BITS-1:0]    head_data_q;
  logic [IDX_W-1:0]        e_q;
  logic [CNT_W-1:0]        k_q;
  logic [CHK_W-1:0]        chunk_q;
  logic [IDX_W-1:0]        slot_q;
  logic [DATA_BITS-1:0]    popped_q;
  status_e                 res_status_q;
  logic                    out_valid_q;
  plfq_out_t               out_word_q;

  logic [DATA_BITS-1:0]    data_rd;
  logic [IDX_W-1:0]        next_rd, prev_rd;
  logic [IDX_W-1:0]        rd_addr;

  logic                    next_we, prev_we;
  logic [IDX_W-1:0]        next_waddr, next_wdata, prev_waddr, prev_wdata;

  logic [PAD_W-1:0]        used_pad;
  logic [SCAN_GROUP-1:0]   grp;
  logic [GRP_W-1:0]        lo;
  logic                    hit;
  logic [CHK_W+GRP_W-1:0]  slot_wide;
  logic [IDX_W-1:0]        slot_found;

  logic                    count_zero, count_one, e_is_head, e_is_tail, rm_mid, out_free;
  logic [CNT_W:0]          k_inc;

  // lowest free entry, one group of eight per cycle
  always_comb begin
    used_pad                     = '1;
    used_pad[POOL_ENTRIES-1:0]   = used_q;
    grp                          = used_pad[chunk_q*SCAN_GROUP +: SCAN_GROUP];
    lo                           = '0;
    hit                          = 1'b0;
    for (int b = SCAN_GROUP - 1; b >= 0; b--) begin
      if (!grp[b]) begin
        lo  = GRP_W'(b);
        hit = 1'b1;
      end
    end
    slot_wide  = {chunk_q, lo};
    slot_found = slot_wide[IDX_W-1:0];
  end

  assign count_zero = (count_q == '0);
  assign count_one  = (count_q == CNT_W'(1));
  assign e_is_head  = (e_q == head_q);
  assign e_is_tail  = (e_q == tail_q);
  assign rm_mid     = cmd_i.rm_commit && !count_one && !e_is_head && !e_is_tail;
  assign k_inc      = (CNT_W + 1)'(k_q) + (CNT_W + 1)'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  // the walk follows the link it just read, one entry per cycle
  assign rd_addr = cmd_i.walk_step ? next_rd : head_q;

  // push links the new entry behind the tail, remove unlinks a middle entry
  assign next_we    = (cmd_i.push_commit && !count_zero) || rm_mid;
  assign next_waddr = cmd_i.push_commit ? tail_q : prev_rd;
  assign next_wdata = cmd_i.push_commit ? slot_q : next_rd;
  assign prev_we    = cmd_i.push_commit || rm_mid;
  assign prev_waddr = cmd_i.push_commit ? slot_q : next_rd;
  assign prev_wdata = cmd_i.push_commit ? (count_zero ? '0 : tail_q) : prev_rd;

  plfq_ram #(.WIDTH(DATA_BITS), .DEPTH(POOL_ENTRIES)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_commit),
    .waddr_i (slot_q),
    .wdata_i (val_q),
    .raddr_i (rd_addr),
    .rdata_o (data_rd)
  );

  plfq_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rd)
  );

  plfq_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      used_q      <= '0;
      head_data_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push_commit) begin
        used_q[slot_q] <= 1'b1;
        tail_q         <= slot_q;
        count_q        <= count_q + CNT_W'(1);
        if (count_zero) begin
          head_q      <= slot_q;
          head_data_q <= val_q;
        end
      end
      if (cmd_i.pop_commit) begin
        used_q[head_q] <= 1'b0;
        count_q        <= count_q - CNT_W'(1);
        if (count_one) begin
          head_q      <= '0;
          tail_q      <= '0;
          head_data_q <= '0;
        end else begin
          head_q <= next_rd;
        end
      end
      if (cmd_i.rm_commit) begin
        used_q[e_q] <= 1'b0;
        count_q     <= count_q - CNT_W'(1);
        if (count_one) begin
          head_q      <= '0;
          tail_q      <= '0;
          head_data_q <= '0;
        end else if (e_is_head) begin
          head_q <= next_rd;
        end else if (e_is_tail) begin
          tail_q <= prev_rd;
        end
      end
      if (cmd_i.head_load) begin
        head_data_q <= data_rd;
      end
      if (cmd_i.resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= in_word_i.func;
      val_q  <= DATA_BITS'(in_word_i.data_value);
    end
    if (cmd_i.decode) begin
      e_q      <= head_q;
      k_q      <= '0;
      chunk_q  <= '0;
      popped_q <= '0;
    end
    if (cmd_i.status_we) begin
      res_status_q <= cmd_i.status_code;
    end
    if (cmd_i.scan) begin
      chunk_q <= chunk_q + CHK_W'(1);
      slot_q  <= slot_found;
    end
    if (cmd_i.pop_commit) begin
      popped_q <= head_data_q;
    end
    if (cmd_i.walk_step) begin
      e_q <= next_rd;
      k_q <= k_inc[CNT_W-1:0];
    end
    if (cmd_i.resp_load) begin
      out_word_q.status       <= res_status_q;
      out_word_q.popped_value <= WORD_W'(popped_q);
      out_word_q.head_value   <= WORD_W'(head_data_q);
      out_word_q.entry_count  <= COUNT_OUT_W'(count_q);
    end
  end

  always_comb begin
    stat_o.func       = func_e'(func_q);
    stat_o.is_full    = (count_q == CNT_W'(POOL_ENTRIES));
    stat_o.is_empty   = count_zero;
    stat_o.scan_hit   = hit;
    stat_o.walk_match = (data_rd == val_q);
    stat_o.walk_last  = (k_inc >= (CNT_W + 1)'(count_q));
    stat_o.count_one  = count_one;
    stat_o.e_is_head  = e_is_head;
    stat_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `PLFQ_ASSERT(a_used_matches_count, clk_i, rst_ni, $countones(used_q) == int'(count_q))
  `PLFQ_ASSERT(a_empty_head_zero, clk_i, rst_ni, (count_q == '0) |-> (head_data_q == '0))
  `PLFQ_ASSERT(a_walk_in_range, clk_i, rst_ni, cmd_i.walk_step |-> (k_inc < (CNT_W + 1)'(count_q)))
  `PLFQ_ASSERT(a_push_slot_free, clk_i, rst_ni, cmd_i.push_commit |-> !used_q[slot_q])
  `PLFQ_ASSERT(a_resp_into_free, clk_i, rst_ni, cmd_i.resp_load |-> out_free)
  `PLFQ_ASSERT_NR(a_reset_no_result, clk_i, (!rst_ni) |=> !out_valid_q)

endmodule
`default_nettype wire

@@ rtl/core/pooled_linked_fifo_queue.sv @@
// top level of the pooled linked fifo queue: controller plus datapath
// one word at a time; a push scans the pool 8 entries per cycle for a free entry, reports full when full
// a pop unlinks the head and fetches the new head value; a remove does so too when the head moves on
// pop and remove report empty on an empty queue; a remove that misses walks every entry
// a remove walks the list one pool ram read per cycle until it matches or reaches the last entry
// asynchronous active-low reset empties the queue and marks every entry free, no clearing pass
`default_nettype none
module pooled_linked_fifo_queue
  import plfq_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int DATA_BITS    = DATA_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire plfq_in_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output plfq_out_t      out_word_o
);

  plfq_cmd_t  cmd;
  plfq_stat_t stat;

  plfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  plfq_dp #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .DATA_BITS    (DATA_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire
